// ===== src/itsort_pkg.sv =====
// Shared types, sizes and the ordering function of the index tracking sorter.
package itsort_pkg;

   // Capacity of one set and the widths that follow from it
   localparam int MaxCount = 32;
   localparam int ValueW   = 32;
   localparam int IndexW   = 5;
   localparam int CountW   = $clog2(MaxCount + 1);

   typedef logic signed [ValueW-1:0] value_type;
   typedef logic [IndexW-1:0]        index_type;
   typedef logic [CountW-1:0]        count_type;

   // One stored value with its arrival position
   typedef struct packed {
      value_type value;
      index_type index;
   } entry_type;

   typedef enum logic {
      ST_LOAD,
      ST_EMIT
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic insert;
      logic pop;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic one_left;
   } status_type;

   // True when a newly arrived value goes ahead of a stored one; a tie keeps
   // the stored value first, since it arrived earlier
   function automatic logic goes_before(input logic desc, input value_type a,
                                        input value_type b);
      logic result;
      result = desc ? (a > b) : (a < b);
      return result;
   endfunction

endpackage

// ===== src/itsort_req_if.sv =====
// Input channel of the sorter: one value of a set per transfer.
interface itsort_req_if import itsort_pkg::*;;
   logic      valid;
   logic      ready;
   value_type sample_value;
   logic      last_in;

   modport source (output valid, output sample_value, output last_in, input ready);
   modport sink (input valid, input sample_value, input last_in, output ready);
endinterface

// ===== src/itsort_rsp_if.sv =====
// Result channel of the sorter: one sorted value and its arrival index per transfer.
interface itsort_rsp_if import itsort_pkg::*;;
   logic      valid;
   logic      ready;
   value_type sorted_value;
   index_type original_index;
   logic      last_out;
   logic      overflowed;

   modport source (output valid, output sorted_value, output original_index,
                   output last_out, output overflowed, input ready);
   modport sink (input valid, input sorted_value, input original_index,
                 input last_out, input overflowed, output ready);
endinterface

// ===== src/index_tracking_sorter_core.sv =====
// Top level of the index tracking sorter: controller, datapath and checks.
//
//   channel   direction  transfer moves
//   req_chan  in         sample_value, last_in
//   rsp_chan  out        sorted_value, original_index, last_out, overflowed
//   csr_*     in         descending order bit
//
// Each value is taken and inserted into its ordered place while the row has room;
// after the closing transfer the set leaves at one result per cycle from the head
// of the cell row while rsp is ready.
// No input is taken while results are going out; rsp stalls hold the head result.
// Reset empties the row and clears the order bit to ascending.
module index_tracking_sorter_core import itsort_pkg::*; (
   input logic          clock,
   input logic          reset,
   itsort_req_if.sink   req_chan,
   itsort_rsp_if.source rsp_chan,
   input logic          csr_write_enable,
   input logic          csr_write_data
);

   cmd_type    cmd;
   status_type status;

   itsort_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_last_in (req_chan.last_in),
      .rsp_ready   (rsp_chan.ready),
      .status      (status),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .cmd         (cmd)
   );

   itsort_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .sample_value     (req_chan.sample_value),
      .status           (status),
      .sorted_value     (rsp_chan.sorted_value),
      .original_index   (rsp_chan.original_index),
      .last_out         (rsp_chan.last_out),
      .overflowed       (rsp_chan.overflowed)
   );

`ifndef NO_ASSERTIONS
   // A closing transfer starts the emit phase in the next cycle
   a_close_starts_emit: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && req_chan.last_in) |=> rsp_chan.valid)
      else $error("closing transfer did not start emission");

   // Loading and emitting never overlap
   a_phases_apart: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("input taken while results pending");

   // The final result ends the set
   a_last_ends_set: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready && rsp_chan.last_out) |=> !rsp_chan.valid)
      else $error("results continued past the final one");

   // The overflow mark appears on the first result only
   a_overflow_once: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.ready) |=> !rsp_chan.overflowed)
      else $error("overflow mark after the first result");
`endif

endmodule

// ===== src/itsort_ctrl.sv =====
// Controller of the sorter: load phase and emit phase.
module itsort_ctrl import itsort_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last_in,
   input  logic       rsp_ready,
   input  status_type status,
   output logic       req_ready,
   output logic       rsp_valid,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // Advance from load to emit on the closing transfer, back once the set is out
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_valid && req_last_in) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_ready && status.one_left) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // Drive handshakes and datapath commands
   always_comb begin
      req_ready  = 1'b0;
      rsp_valid  = 1'b0;
      cmd.insert = 1'b0;
      cmd.pop    = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready  = 1'b1;
            cmd.insert = req_valid;
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            cmd.pop   = rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== src/itsort_datapath.sv =====
// Datapath of the sorter: a row of ordered cells filled by insertion, drained from the head.
module itsort_datapath import itsort_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  cmd_type    cmd,
   input  value_type  sample_value,
   output status_type status,
   output value_type  sorted_value,
   output index_type  original_index,
   output logic       last_out,
   output logic       overflowed
);

   entry_type             cell_ff [MaxCount];
   entry_type             cell_in [MaxCount];
   count_type             count_ff, count_in;
   logic                  ovf_ff, ovf_in;
   logic                  desc_ff, desc_in;
   logic [MaxCount-1:0]   ahead;
   entry_type             new_entry;

   // Compare the arriving value against every cell at once
   always_comb begin
      for (int i = 0; i < MaxCount; i++) begin
         ahead[i] = goes_before(desc_ff, sample_value, cell_ff[i].value);
      end
   end

   // Insert on load, shift towards the head on each result transfer
   always_comb begin
      new_entry.value = sample_value;
      new_entry.index = IndexW'(count_ff);
      count_in = count_ff;
      ovf_in   = ovf_ff;
      for (int i = 0; i < MaxCount; i++) begin
         cell_in[i] = cell_ff[i];
      end
      if (cmd.insert) begin
         if (count_ff < CountW'(MaxCount)) begin
            if (count_ff == '0 || ahead[0]) begin
               cell_in[0] = new_entry;
            end
            for (int i = 1; i < MaxCount; i++) begin
               if (CountW'(i - 1) < count_ff && ahead[i-1]) begin
                  cell_in[i] = cell_ff[i-1];
               end else if (CountW'(i) < count_ff ? ahead[i]
                                                    : (CountW'(i) == count_ff)) begin
                  cell_in[i] = new_entry;
               end
            end
            count_in = count_ff + CountW'(1);
         end else begin
            ovf_in = 1'b1;
         end
      end else if (cmd.pop) begin
         for (int i = 0; i < MaxCount - 1; i++) begin
            cell_in[i] = cell_ff[i+1];
         end
         count_in = count_ff - CountW'(1);
         ovf_in   = 1'b0;
      end
   end

   // Hold the order register between writes
   always_comb begin
      desc_in = csr_write_enable ? csr_write_data : desc_ff;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MaxCount; i++) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         desc_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         desc_ff  <= desc_in;
      end
   end

   // Present the head cell as the current result
   assign sorted_value    = cell_ff[0].value;
   assign original_index  = cell_ff[0].index;
   assign last_out        = (count_ff == CountW'(1));
   assign overflowed      = ovf_ff;
   assign status.one_left = last_out;

endmodule
